// File: rtl/core/sal_pkg.sv
// ----------------------------------------------------------------------------
// sal_pkg
// Shared types, token codes and character constants of the array literal
// tokenizer.
// ----------------------------------------------------------------------------
package sal_pkg;

  // token codes
  localparam logic [2:0] K_ROW_START = 3'd0;
  localparam logic [2:0] K_ROW_END   = 3'd1;
  localparam logic [2:0] K_VALUE     = 3'd2;
  localparam logic [2:0] K_EMPTY     = 3'd3;
  localparam logic [2:0] K_NULL      = 3'd4;
  localparam logic [2:0] K_DONE      = 3'd5;
  localparam logic [2:0] K_ESC_END   = 3'd6;
  localparam logic [2:0] K_UNTERM    = 3'd7;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  // "NULL", element 0 is the first letter
  localparam logic [3:0][7:0] NULL_WORD = {8'h4C, 8'h4C, 8'h55, 8'h4E};

  localparam int unsigned MAX_TOK = 4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       vend;
  } sal_tok_t;

  // all tokens caused by one input word
  typedef struct packed {
    logic [2:0]          n;
    sal_tok_t [MAX_TOK-1:0] tok;
  } sal_bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sal_q_stat_t;

  // append a token; a full bundle drops the extra one
  function automatic sal_bundle_t push_tok(sal_bundle_t b, logic [2:0] kind,
                                           logic [7:0] data, logic vend);
    sal_bundle_t r;
    r = b;
    if (b.n < 3'(MAX_TOK)) begin
      r.tok[b.n[1:0]] = '{kind: kind, data: data, vend: vend};
      r.n = b.n + 3'd1;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/sql_array_literal_tokenizer.sv
// ----------------------------------------------------------------------------
// sql_array_literal_tokenizer
// Tokenizer for the text of an SQL array literal, one text byte per word.
// ----------------------------------------------------------------------------
// Input channel: in_tdata carries one text byte, in_tuser marks the first
// byte of a new literal. A zero byte ends the text. Output channel: one token
// per word, kind and value-end flag in out_tuser, decoded byte in out_tdata,
// out_tlast on the last token caused by one input byte.
// The parser takes one byte per cycle and pushes all tokens of that byte
// (zero to four) as one bundle into a FIFO_DEPTH-entry queue; the serializer
// drains one token per cycle. Sustained rate is one byte per cycle while
// bytes average at most one token; otherwise the output port's one token
// per cycle sets the pace. An accepted byte reaches its first token through
// the queue write and the output register. A string byte waits for the
// following byte, so its token may come one byte later.
// Reset (synchronous, rst_n low) empties the queue and returns the parser to
// text start. A stalled receiver holds the output register; the queue keeps
// taking bytes until it is full, then in_tready drops.
// After done or an error all bytes are dropped until in_tuser is set.
// ----------------------------------------------------------------------------
module sql_array_literal_tokenizer #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tuser,   // [0] start_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] value_byte
  output logic [3:0] out_tuser,  // [2:0] token_kind, [3] value_end
  output logic       out_tlast   // run_last
);
  import sal_pkg::*;

  sal_q_stat_t q_stat;
  sal_bundle_t push_data, head;
  logic        push, pop;
  logic [2:0]  token_kind;
  logic        value_end;

  sal_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .text_byte     (in_tdata),
    .start_of_text (in_tuser),
    .q_stat        (q_stat),
    .push          (push),
    .push_data     (push_data)
  );

  sal_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  sal_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .token_kind (token_kind),
    .value_byte (out_tdata),
    .value_end  (value_end),
    .run_last   (out_tlast)
  );

  assign out_tuser = {value_end, token_kind};

  // value_end only ever tags a value token
  a_vend_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && value_end |-> token_kind == K_VALUE)
    else $error("value_end on a non-value token");

  // non-value tokens carry a zero byte
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && token_kind != K_VALUE |-> out_tdata == 8'd0)
    else $error("data on a non-value token");

  // terminal tokens close the run of their byte
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (token_kind == K_DONE || token_kind == K_ESC_END ||
                   token_kind == K_UNTERM) |-> out_tlast)
    else $error("terminal token not last of its run");

  // no byte is taken while the queue is full
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_tready)
    else $error("input ready with full queue");

endmodule

// File: rtl/core/sal_front.sv
// ----------------------------------------------------------------------------
// sal_front
// Parser: takes one text word per cycle unless the queue is full, advances
// the parse mode and builds the bundle of tokens that the word causes.
// ----------------------------------------------------------------------------
module sal_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           text_byte,
  input  logic                 start_of_text,
  input  sal_pkg::sal_q_stat_t q_stat,
  output logic                 push,
  output sal_pkg::sal_bundle_t push_data
);
  import sal_pkg::*;

  typedef enum logic [3:0] {
    M_BETWEEN,
    M_AFTER,
    M_SQ,
    M_SQ_ESC,
    M_SQ_QUOTE,
    M_DQ,
    M_DQ_ESC,
    M_UNQ,
    M_STOPPED
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        npm_r, npm_nxt;
  logic [7:0]  hb_r, hb_nxt;
  sal_bundle_t bnd;
  logic        accept;
  logic        do_after, do_between, do_unq, do_end, is_sep;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign is_sep   = (text_byte == CH_COMMA) || (text_byte == CH_SEMI);

  always_comb begin
    mode_nxt   = start_of_text ? M_BETWEEN : mode_r;
    cnt_nxt    = start_of_text ? 3'd0 : cnt_r;
    npm_nxt    = start_of_text ? 1'b1 : npm_r;
    hb_nxt     = hb_r;
    bnd        = '0;
    do_after   = 1'b0;
    do_between = 1'b0;
    do_unq     = 1'b0;
    do_end     = 1'b0;

    unique case (mode_nxt)
      M_BETWEEN: do_between = 1'b1;
      M_AFTER:   do_after = 1'b1;
      M_SQ, M_DQ: begin
        if ((mode_nxt == M_SQ && text_byte == CH_SQUOTE) ||
            (mode_nxt == M_DQ && text_byte == CH_DQUOTE)) begin
          if (mode_nxt == M_SQ) begin
            mode_nxt = M_SQ_QUOTE;
          end else begin
            // double quote closes at once
            if (cnt_nxt != 3'd0) bnd = push_tok(bnd, K_VALUE, hb_nxt, 1'b1);
            else                 bnd = push_tok(bnd, K_EMPTY, CH_NUL, 1'b0);
            cnt_nxt  = 3'd0;
            npm_nxt  = 1'b1;
            mode_nxt = M_AFTER;
          end
        end else if (text_byte == CH_BSLASH) begin
          mode_nxt = (mode_nxt == M_SQ) ? M_SQ_ESC : M_DQ_ESC;
        end else if (text_byte == CH_NUL) begin
          bnd      = push_tok(bnd, K_UNTERM, CH_NUL, 1'b0);
          cnt_nxt  = 3'd0;
          npm_nxt  = 1'b1;
          mode_nxt = M_STOPPED;
        end else begin
          if (cnt_nxt != 3'd0) bnd = push_tok(bnd, K_VALUE, hb_nxt, 1'b0);
          hb_nxt  = text_byte;
          cnt_nxt = 3'd1;
        end
      end
      M_SQ_ESC, M_DQ_ESC: begin
        if (text_byte == CH_NUL) begin
          bnd      = push_tok(bnd, K_ESC_END, CH_NUL, 1'b0);
          cnt_nxt  = 3'd0;
          npm_nxt  = 1'b1;
          mode_nxt = M_STOPPED;
        end else begin
          if (cnt_nxt != 3'd0) bnd = push_tok(bnd, K_VALUE, hb_nxt, 1'b0);
          hb_nxt   = text_byte;
          cnt_nxt  = 3'd1;
          mode_nxt = (mode_nxt == M_SQ_ESC) ? M_SQ : M_DQ;
        end
      end
      M_SQ_QUOTE: begin
        if (text_byte == CH_SQUOTE) begin
          // doubled quote is a literal quote
          if (cnt_nxt != 3'd0) bnd = push_tok(bnd, K_VALUE, hb_nxt, 1'b0);
          hb_nxt   = text_byte;
          cnt_nxt  = 3'd1;
          mode_nxt = M_SQ;
        end else begin
          if (cnt_nxt != 3'd0) bnd = push_tok(bnd, K_VALUE, hb_nxt, 1'b1);
          else                 bnd = push_tok(bnd, K_EMPTY, CH_NUL, 1'b0);
          cnt_nxt  = 3'd0;
          npm_nxt  = 1'b1;
          do_after = 1'b1;
        end
      end
      M_UNQ: begin
        if (is_sep || text_byte == CH_RBRACE || text_byte == CH_NUL) do_end = 1'b1;
        else                                                           do_unq = 1'b1;
      end
      M_STOPPED: mode_nxt = M_STOPPED;
      default:   mode_nxt = M_STOPPED;
    endcase

    // close an unquoted value, then treat the terminator as after a token
    if (do_end) begin
      if (npm_nxt && cnt_nxt == 3'd4) begin
        bnd = push_tok(bnd, K_NULL, CH_NUL, 1'b0);
      end else if (cnt_nxt == 3'd0) begin
        bnd = push_tok(bnd, K_EMPTY, CH_NUL, 1'b0);
      end else begin
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < cnt_nxt)
            bnd = push_tok(bnd, K_VALUE, (i == 0) ? hb_nxt : NULL_WORD[2'(i)],
                           (3'(i + 1) == cnt_nxt));
        end
      end
      cnt_nxt  = 3'd0;
      npm_nxt  = 1'b1;
      do_after = 1'b1;
    end

    if (do_after) begin
      if (is_sep) mode_nxt = M_BETWEEN;
      else        do_between = 1'b1;
    end

    if (do_between) begin
      unique case (text_byte)
        CH_NUL: begin
          bnd      = push_tok(bnd, K_DONE, CH_NUL, 1'b0);
          mode_nxt = M_STOPPED;
        end
        CH_LBRACE: begin
          bnd      = push_tok(bnd, K_ROW_START, CH_NUL, 1'b0);
          mode_nxt = M_AFTER;
        end
        CH_RBRACE: begin
          bnd      = push_tok(bnd, K_ROW_END, CH_NUL, 1'b0);
          mode_nxt = M_AFTER;
        end
        CH_SQUOTE: begin
          cnt_nxt  = 3'd0;
          npm_nxt  = 1'b1;
          mode_nxt = M_SQ;
        end
        CH_DQUOTE: begin
          cnt_nxt  = 3'd0;
          npm_nxt  = 1'b1;
          mode_nxt = M_DQ;
        end
        CH_COMMA, CH_SEMI: begin
          bnd      = push_tok(bnd, K_EMPTY, CH_NUL, 1'b0);
          mode_nxt = M_BETWEEN;
        end
        default: begin
          cnt_nxt  = 3'd0;
          npm_nxt  = 1'b1;
          mode_nxt = M_UNQ;
          do_unq   = 1'b1;
        end
      endcase
    end

    // one unquoted byte: hold a NULL prefix, else flush and hold this byte
    if (do_unq) begin
      if (npm_nxt && cnt_nxt < 3'd4 && text_byte == NULL_WORD[cnt_nxt[1:0]]) begin
        if (cnt_nxt == 3'd0) hb_nxt = text_byte;
        cnt_nxt = cnt_nxt + 3'd1;
      end else begin
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < cnt_nxt)
            bnd = push_tok(bnd, K_VALUE, (i == 0) ? hb_nxt : NULL_WORD[2'(i)], 1'b0);
        end
        npm_nxt = 1'b0;
        hb_nxt  = text_byte;
        cnt_nxt = 3'd1;
      end
    end
  end

  assign push      = accept && (bnd.n != 3'd0);
  assign push_data = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_BETWEEN;
      cnt_r  <= 3'd0;
      npm_r  <= 1'b1;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      npm_r  <= npm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) hb_r <= hb_nxt;
  end

endmodule

// File: rtl/core/sal_fifo.sv
// ----------------------------------------------------------------------------
// sal_fifo
// Short queue of token bundles between the parser and the serializer.
// ----------------------------------------------------------------------------
module sal_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sal_pkg::sal_bundle_t push_data,
  input  logic                 pop,
  output sal_pkg::sal_bundle_t head,
  output sal_pkg::sal_q_stat_t stat
);
  import sal_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sal_bundle_t     mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push)
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (do_pop)
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    if (do_push && !do_pop)      cnt_nxt = cnt_r + CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// File: rtl/core/sal_back.sv
// ----------------------------------------------------------------------------
// sal_back
// Serializer: walks the head bundle one token per cycle into the output
// register while it is free, and pops the bundle after its last token.
// ----------------------------------------------------------------------------
module sal_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sal_pkg::sal_bundle_t head,
  input  sal_pkg::sal_q_stat_t q_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           token_kind,
  output logic [7:0]           value_byte,
  output logic                 value_end,
  output logic                 run_last
);
  import sal_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r;
  sal_tok_t   tok_r;
  logic       last_r;
  logic       load, is_last;

  assign load    = !q_stat.empty && (!valid_r || out_ready);
  assign is_last = ({1'b0, idx_r} + 3'd1) == head.n;
  assign pop     = load && is_last;
  assign idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= idx_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r  <= head.tok[idx_r];
      last_r <= is_last;
    end
  end

  assign out_valid  = valid_r;
  assign token_kind = tok_r.kind;
  assign value_byte = tok_r.data;
  assign value_end  = tok_r.vend;
  assign run_last   = last_r;

endmodule

// File: tb/tb_sql_array_literal_tokenizer.sv
// ----------------------------------------------------------------------------
// tb_sql_array_literal_tokenizer
// Self-checking bench for the array literal tokenizer. Array literal texts
// go in one byte per word: a short directed set first, then random nested
// rows with quoted and unquoted values, truncated texts and raw noise. A
// scoreboard class parses the same bytes and queues the tokens due. Each
// token that leaves the block is checked against the oldest one due. Both
// sides of the block insert random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_sql_array_literal_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import sal_pkg::*;

  localparam int unsigned TEXT_WORDS = 240;
  localparam int unsigned QUIET_LIMIT = 200;
  localparam int unsigned TAIL_CYCLES = 16;

  typedef enum logic [3:0] {
    PM_BETWEEN, PM_AFTER, PM_SQ, PM_SQ_ESC, PM_SQ_QUOTE,
    PM_DQ, PM_DQ_ESC, PM_UNQ, PM_STOPPED
  } parse_mode_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       vend;
    logic       last;
  } token_t;

  class token_board;
    parse_mode_t mode;
    logic [7:0]  held [4];
    int unsigned held_n;
    bit          null_ok;
    bit          started;
    token_t      run_q [$];
    token_t      tokens_due [$];
    int unsigned n_checked;
    int unsigned n_bad;
    int unsigned kind_seen [8];

    function new();
      start_fresh();
      n_checked = 0;
      n_bad = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void start_fresh();
      mode = PM_BETWEEN;
      clear_value();
    endfunction

    function void clear_value();
      held_n = 0;
      null_ok = 1'b1;
      started = 1'b0;
    endfunction

    // a full run drops any further token
    function void add_token(logic [2:0] kind, logic [7:0] data, logic vend);
      token_t t;
      t = '{kind: kind, data: data, vend: vend, last: 1'b0};
      if (run_q.size() < MAX_TOK) run_q.insert(run_q.size(), t);
    endfunction

    // a string byte waits until the next one shows whether it ends the value
    function void take_quoted(logic [7:0] c);
      if (held_n != 0) add_token(K_VALUE, held[0], 1'b0);
      held[0] = c;
      held_n = 1;
    endfunction

    function void close_quoted();
      if (held_n != 0) add_token(K_VALUE, held[0], 1'b1);
      else add_token(K_EMPTY, 8'h00, 1'b0);
      clear_value();
    endfunction

    function void take_unquoted(logic [7:0] c);
      if (null_ok && held_n < 4 && c == NULL_WORD[held_n[1:0]]) begin
        held[held_n[1:0]] = c;
        held_n++;
        return;
      end
      for (int unsigned i = 0; i < held_n && i < 4; i++)
        add_token(K_VALUE, held[i], 1'b0);
      null_ok = 1'b0;
      held[0] = c;
      held_n = 1;
    endfunction

    function void end_unquoted(logic [7:0] c);
      if (null_ok && held_n == 4) begin
        add_token(K_NULL, 8'h00, 1'b0);
      end else if (held_n == 0) begin
        add_token(K_EMPTY, 8'h00, 1'b0);
      end else begin
        for (int unsigned i = 0; i < held_n && i < 4; i++)
          add_token(K_VALUE, held[i], i + 1 == held_n);
      end
      clear_value();
      after_token(c);
    endfunction

    function void between_tokens(logic [7:0] c);
      case (c)
        CH_NUL: begin
          add_token(K_DONE, 8'h00, 1'b0);
          mode = PM_STOPPED;
        end
        CH_LBRACE: begin
          add_token(K_ROW_START, 8'h00, 1'b0);
          mode = PM_AFTER;
        end
        CH_RBRACE: begin
          add_token(K_ROW_END, 8'h00, 1'b0);
          mode = PM_AFTER;
        end
        CH_SQUOTE: begin
          clear_value();
          started = 1'b1;
          mode = PM_SQ;
        end
        CH_DQUOTE: begin
          clear_value();
          started = 1'b1;
          mode = PM_DQ;
        end
        CH_COMMA, CH_SEMI: begin
          add_token(K_EMPTY, 8'h00, 1'b0);
          mode = PM_BETWEEN;
        end
        default: begin
          clear_value();
          started = 1'b1;
          mode = PM_UNQ;
          take_unquoted(c);
        end
      endcase
    endfunction

    // swallow one separator right after a token
    function void after_token(logic [7:0] c);
      if (c == CH_COMMA || c == CH_SEMI) mode = PM_BETWEEN;
      else between_tokens(c);
    endfunction

    function void note_byte(logic [7:0] c, logic sot);
      token_t t;
      run_q.delete();
      if (sot) start_fresh();
      case (mode)
        PM_BETWEEN: between_tokens(c);
        PM_AFTER: after_token(c);
        PM_SQ, PM_DQ: begin
          if (mode == PM_SQ && c == CH_SQUOTE) begin
            mode = PM_SQ_QUOTE;
          end else if (mode == PM_DQ && c == CH_DQUOTE) begin
            close_quoted();
            mode = PM_AFTER;
          end else if (c == CH_BSLASH) begin
            mode = (mode == PM_SQ) ? PM_SQ_ESC : PM_DQ_ESC;
          end else if (c == CH_NUL) begin
            add_token(K_UNTERM, 8'h00, 1'b0);
            clear_value();
            mode = PM_STOPPED;
          end else begin
            take_quoted(c);
          end
        end
        PM_SQ_ESC, PM_DQ_ESC: begin
          if (c == CH_NUL) begin
            add_token(K_ESC_END, 8'h00, 1'b0);
            clear_value();
            mode = PM_STOPPED;
          end else begin
            take_quoted(c);
            mode = (mode == PM_SQ_ESC) ? PM_SQ : PM_DQ;
          end
        end
        PM_SQ_QUOTE: begin
          if (c == CH_SQUOTE) begin
            take_quoted(c);
            mode = PM_SQ;
          end else begin
            close_quoted();
            after_token(c);
          end
        end
        PM_UNQ: begin
          if (c == CH_COMMA || c == CH_SEMI || c == CH_RBRACE || c == CH_NUL)
            end_unquoted(c);
          else
            take_unquoted(c);
        end
        default: mode = PM_STOPPED;
      endcase
      foreach (run_q[i]) begin
        t = run_q[i];
        t.last = (i == run_q.size() - 1);
        tokens_due.insert(tokens_due.size(), t);
      end
    endfunction

    function void report(string what, token_t want, token_t got);
      n_bad++;
      if (n_bad <= 10)
        $display("[%0t] %s: want kind %0d byte %02h end %0b last %0b, %s",
                 $time, what, want.kind, want.data, want.vend, want.last,
                 $sformatf("got kind %0d byte %02h end %0b last %0b",
                           got.kind, got.data, got.vend, got.last));
    endfunction

    function void check_token(token_t got);
      token_t want;
      n_checked++;
      kind_seen[got.kind]++;
      if (tokens_due.size() == 0) begin
        report("token with none due", '0, got);
        return;
      end
      want = tokens_due.pop_front();
      if (got.kind !== want.kind || got.data !== want.data ||
          got.vend !== want.vend || got.last !== want.last)
        report("token mismatch", want, got);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tuser;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [3:0] out_tuser;
  logic       out_tlast;

  token_board  board;
  logic [7:0]  lit [$];
  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned stall_left;
  int unsigned quiet;
  int unsigned n_literals;
  int unsigned n_words;
  string       null_words [5] = '{"NULL", "NUL", "NULLS", "N", "NULL{"};

  sql_array_literal_tokenizer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // receiver: stall a random number of cycles after each word
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_token('{kind: out_tuser[2:0], data: out_tdata,
                          vend: out_tuser[3], last: out_tlast});
      stall_left = rx_idle_on ? $urandom_range(0, 3) : 0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $time, quiet);
        $display("tb_sql_array_literal_tokenizer: errors");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic sot);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tuser <= sot;
    do @(posedge clk); while (!in_tready);
    board.note_byte(c, sot);
    n_words++;
  endtask

  task automatic send_literal();
    foreach (lit[i]) send_byte(lit[i], i == 0);
    n_literals++;
  endtask

  // hold the sender until every token due has left the block
  task automatic wait_for_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.tokens_due.size() != 0) @(posedge clk);
  endtask

  task automatic put_byte(input logic [7:0] c);
    lit.insert(lit.size(), c);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_unq(input bit first);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CH_COMMA || c == CH_SEMI || c == CH_RBRACE ||
           (first && (c == CH_LBRACE || c == CH_SQUOTE || c == CH_DQUOTE)));
    return c;
  endfunction

  task automatic gen_quoted(input logic [7:0] q);
    logic [7:0]  c;
    int unsigned r;
    put_byte(q);
    repeat ($urandom_range(0, 5)) begin
      r = $urandom_range(0, 9);
      c = (r == 0) ? q : (r == 1) ? CH_BSLASH : (r == 2) ? (CH_SQUOTE ^ CH_DQUOTE ^ q)
        : 8'($urandom_range(1, 255));
      if (c == q && q == CH_SQUOTE && $urandom_range(0, 1)) put_byte(q);
      else if (c == q || c == CH_BSLASH || $urandom_range(0, 7) == 0) put_byte(CH_BSLASH);
      put_byte(c);
    end
    put_byte(q);
  endtask

  task automatic gen_row(input int unsigned depth);
    int unsigned count;
    put_byte(CH_LBRACE);
    count = $urandom_range(0, 4);
    for (int unsigned i = 0; i < count; i++) begin
      if (i > 0) put_byte(($urandom_range(0, 3) == 0) ? CH_SEMI : CH_COMMA);
      case ($urandom_range(0, 9))
        0, 1: begin
          put_byte(rand_unq(1'b1));
          repeat ($urandom_range(0, 3)) put_byte(rand_unq(1'b0));
        end
        2: add_str(null_words[$urandom_range(0, 4)]);
        3, 4: gen_quoted(CH_SQUOTE);
        5, 6: gen_quoted(CH_DQUOTE);
        7, 8: begin
          if (depth < 2) gen_row(depth + 1);
          else add_str("NULL");
        end
        default: ;  // leave the slot empty
      endcase
    end
    put_byte(CH_RBRACE);
  endtask

  // mostly well-formed rows; the rest cut short, broken or plain noise
  task automatic build_literal();
    int unsigned shape;
    int unsigned cut;
    lit.delete();
    shape = $urandom_range(0, 9);
    if (shape == 9) begin
      repeat ($urandom_range(4, 12)) put_byte(8'($urandom_range(0, 255)));
      put_byte(CH_NUL);
    end else begin
      gen_row(0);
      if (shape > 5) begin
        cut = $urandom_range(1, lit.size());
        lit = lit[0:cut-1];
      end
      case (shape)
        6: add_str("'q");
        7: begin
          put_byte(CH_DQUOTE);
          put_byte(CH_BSLASH);
        end
        default: ;
      endcase
      // abandoned texts end without a zero byte
      if (shape != 8) put_byte(CH_NUL);
    end
  endtask

  initial begin
    int unsigned random_words;
    bit          paused;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    stall_left = 0;
    quiet = 0;
    n_literals = 0;
    n_words = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    board = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: null word, lone separator, doubled quote and escape in a
    // single-quoted string, then done
    lit.delete();
    add_str("{NULL,,'x''\\y'}");
    put_byte(CH_NUL);
    send_literal();
    // escape cut by the zero byte, then a word dropped after the error
    lit.delete();
    add_str("\"\\");
    put_byte(CH_NUL);
    send_literal();
    send_byte(8'hFF, 1'b0);
    // top byte value closed by a quote, done straight after
    lit.delete();
    put_byte(CH_SQUOTE);
    put_byte(8'hFF);
    put_byte(CH_SQUOTE);
    put_byte(CH_NUL);
    send_literal();
    // string left open at the zero byte
    lit.delete();
    add_str("'a");
    put_byte(CH_NUL);
    send_literal();

    random_words = 0;
    paused = 1'b0;
    while (random_words < TEXT_WORDS) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      build_literal();
      random_words += lit.size();
      send_literal();
      if (!paused && random_words >= TEXT_WORDS / 2) begin
        wait_for_drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (board.tokens_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (board.tokens_due.size() != 0) begin
      $display("%0d tokens never arrived", board.tokens_due.size());
      board.n_bad++;
    end
    $display("sent %0d literals in %0d text words, checked %0d tokens, %0d bad",
             n_literals, n_words, board.n_checked, board.n_bad);
    $display("by kind: open %0d close %0d value %0d empty %0d null %0d %s",
             board.kind_seen[K_ROW_START], board.kind_seen[K_ROW_END],
             board.kind_seen[K_VALUE], board.kind_seen[K_EMPTY], board.kind_seen[K_NULL],
             $sformatf("done %0d esc_end %0d unterm %0d", board.kind_seen[K_DONE],
                       board.kind_seen[K_ESC_END], board.kind_seen[K_UNTERM]));
    if (board.n_bad == 0) begin
      $display("tb_sql_array_literal_tokenizer: clean");
    end else begin
      $display("tb_sql_array_literal_tokenizer: errors");
    end
    $finish;
  end

endmodule
